// ===== src/ut8_pkg.sv =====
// Shared constants, types and the UTF-8 encoder for the UTF-16 to UTF-8 transcoder.
package ut8_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 24;
  localparam int unsigned MaxBytes = 6;

  localparam logic CFG_COUNT_ONLY   = 1'b0;
  localparam logic CFG_OUT_CAPACITY = 1'b1;

  localparam logic [CpW-1:0]    REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [15:0]       SURR_ANY_MASK  = 16'hF800;
  localparam logic [15:0]       SURR_BASE      = 16'hD800;
  localparam logic [15:0]       SURR_KIND_MASK = 16'hFC00;
  localparam logic [15:0]       SURR_LOW_BASE  = 16'hDC00;
  localparam logic [CpW-1:0]    SUPP_OFFSET    = 21'h010000;
  localparam logic [CpW-1:0]    MAX1           = 21'h00007F;
  localparam logic [CpW-1:0]    MAX2           = 21'h0007FF;
  localparam logic [CpW-1:0]    MAX3           = 21'h00FFFF;
  localparam logic [7:0]        CONT_TAG       = 8'h80;
  localparam logic [7:0]        LEAD2_TAG      = 8'hC0;
  localparam logic [7:0]        LEAD3_TAG      = 8'hE0;
  localparam logic [7:0]        LEAD4_TAG      = 8'hF0;
  localparam logic [CountW-1:0] COUNT_MAX      = 24'hFFFFFF;

  typedef struct packed {
    logic [2:0]  size;
    logic [31:0] bytes;
  } enc_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_t;

  typedef struct packed {
    logic [8*MaxBytes-1:0] bytes;
    logic [2:0]            nbytes;
    logic                  summ;
    logic [CountW-1:0]     base;
    logic [CountW-1:0]     sum_total;
  } job_t;

  function automatic enc_t utf8_encode(input logic [CpW-1:0] cp);
    enc_t e;
    e = '0;
    if (cp <= MAX1) begin
      e.size  = 3'd1;
      e.bytes = {24'h0, cp[7:0]};
    end else if (cp <= MAX2) begin
      e.size  = 3'd2;
      e.bytes = {16'h0, CONT_TAG | {2'b00, cp[5:0]}, LEAD2_TAG | {3'b000, cp[10:6]}};
    end else if (cp <= MAX3) begin
      e.size  = 3'd3;
      e.bytes = {8'h0, CONT_TAG | {2'b00, cp[5:0]}, CONT_TAG | {2'b00, cp[11:6]},
                 LEAD3_TAG | {4'h0, cp[15:12]}};
    end else begin
      e.size  = 3'd4;
      e.bytes = {CONT_TAG | {2'b00, cp[5:0]}, CONT_TAG | {2'b00, cp[11:6]},
                 CONT_TAG | {2'b00, cp[17:12]}, LEAD4_TAG | {5'h00, cp[20:18]}};
    end
    return e;
  endfunction

endpackage

// ===== src/ut8_dec.sv =====
// Surrogate pairing, capacity check, byte packing: one code unit per take cycle.
module ut8_dec import ut8_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  unit_t             unit,
  input  logic              count_only,
  input  logic [CountW-1:0] out_capacity,
  output job_t              job
);

  logic              pv_r, pv_nxt;
  logic [9:0]        ph_r, ph_nxt;
  logic [CountW-1:0] bc_r, bc_nxt;

  logic              is_low, is_surr, is_high;
  logic              cpa_vld, cpb_vld;
  logic [CpW-1:0]    cpa, cpb;
  enc_t              enc_a, enc_b;
  logic [CountW:0]   sum_a, sum_b;
  logic [CountW-1:0] cnt_a, cnt_b;
  logic              emit_a, emit_b;
  logic [2:0]        na, nb;
  logic [47:0]       vec_a, vec_b;

  always_comb begin
    is_low  = (unit.code_unit & SURR_KIND_MASK) == SURR_LOW_BASE;
    is_high = (unit.code_unit & SURR_KIND_MASK) == SURR_BASE;
    is_surr = (unit.code_unit & SURR_ANY_MASK) == SURR_BASE;

    cpa_vld = pv_r;
    cpa     = is_low ? (({1'b0, ph_r, 10'h000} | {11'h000, unit.code_unit[9:0]}) + SUPP_OFFSET)
                     : REPLACEMENT_CP;
    cpb_vld = !(pv_r && is_low) && !(is_high && !unit.last_unit);
    cpb     = is_surr ? REPLACEMENT_CP : {5'h00, unit.code_unit};

    enc_a  = utf8_encode(cpa);
    sum_a  = {1'b0, bc_r} + {22'h0, enc_a.size};
    emit_a = 1'b0;
    cnt_a  = bc_r;
    if (cpa_vld) begin
      if (count_only) begin
        cnt_a = sum_a[CountW] ? COUNT_MAX : sum_a[CountW-1:0];
      end else if (sum_a <= {1'b0, out_capacity}) begin
        cnt_a  = sum_a[CountW-1:0];
        emit_a = 1'b1;
      end
    end

    enc_b  = utf8_encode(cpb);
    sum_b  = {1'b0, cnt_a} + {22'h0, enc_b.size};
    emit_b = 1'b0;
    cnt_b  = cnt_a;
    if (cpb_vld) begin
      if (count_only) begin
        cnt_b = sum_b[CountW] ? COUNT_MAX : sum_b[CountW-1:0];
      end else if (sum_b <= {1'b0, out_capacity}) begin
        cnt_b  = sum_b[CountW-1:0];
        emit_b = 1'b1;
      end
    end

    na    = emit_a ? enc_a.size : 3'd0;
    nb    = emit_b ? enc_b.size : 3'd0;
    vec_a = emit_a ? {16'h0, enc_a.bytes} : 48'h0;
    vec_b = emit_b ? {16'h0, enc_b.bytes} : 48'h0;

    job.bytes     = vec_a | (vec_b << {na, 3'b000});
    job.nbytes    = na + nb;
    job.summ      = unit.last_unit;
    job.base      = bc_r;
    job.sum_total = cnt_b;

    pv_nxt = pv_r;
    ph_nxt = ph_r;
    bc_nxt = bc_r;
    if (take) begin
      pv_nxt = is_high && !unit.last_unit;
      ph_nxt = (is_high && !unit.last_unit) ? unit.code_unit[9:0] : 10'h000;
      bc_nxt = unit.last_unit ? '0 : cnt_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ph_r <= '0;
      bc_r <= '0;
    end else begin
      pv_r <= pv_nxt;
      ph_r <= ph_nxt;
      bc_r <= bc_nxt;
    end
  end

endmodule

// ===== src/ut8_ser.sv =====
// Job register and output register that deliver one result per cycle while out_stall is low.
module ut8_ser import ut8_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  job_t              job,
  output logic              job_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_is_byte,
  output logic              out_last_of_run,
  output logic [CountW-1:0] out_byte_total
);

  logic                  busy_r, busy_nxt;
  logic [8*MaxBytes-1:0] bytes_r, bytes_nxt;
  logic [2:0]            rem_r, rem_nxt;
  logic                  summ_r, summ_nxt;
  logic [CountW-1:0]     tot_r, tot_nxt;
  logic [CountW-1:0]     sumtot_r, sumtot_nxt;

  logic                  ov_r, ov_nxt;
  logic [7:0]            ob_r, ob_nxt;
  logic                  oisb_r, oisb_nxt;
  logic                  olast_r, olast_nxt;
  logic [CountW-1:0]     otot_r, otot_nxt;

  logic                  emit, cur_last, load;

  always_comb begin
    emit      = busy_r && (!ov_r || !out_stall);
    cur_last  = (rem_r == 3'd0) || (rem_r == 3'd1 && !summ_r);
    job_ready = !busy_r || (emit && cur_last);
    load      = job_valid && job_ready;

    busy_nxt   = busy_r;
    bytes_nxt  = bytes_r;
    rem_nxt    = rem_r;
    summ_nxt   = summ_r;
    tot_nxt    = tot_r;
    sumtot_nxt = sumtot_r;
    if (emit) begin
      busy_nxt = !cur_last;
      if (rem_r != 3'd0) begin
        bytes_nxt = bytes_r >> 8;
        rem_nxt   = rem_r - 3'd1;
        tot_nxt   = tot_r + 24'd1;
      end
    end
    if (load) begin
      busy_nxt   = (job.nbytes != 3'd0) || job.summ;
      bytes_nxt  = job.bytes;
      rem_nxt    = job.nbytes;
      summ_nxt   = job.summ;
      tot_nxt    = job.base;
      sumtot_nxt = job.sum_total;
    end

    ov_nxt    = ov_r && out_stall;
    ob_nxt    = ob_r;
    oisb_nxt  = oisb_r;
    olast_nxt = olast_r;
    otot_nxt  = otot_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      olast_nxt = cur_last;
      if (rem_r != 3'd0) begin
        ob_nxt   = bytes_r[7:0];
        oisb_nxt = 1'b1;
        otot_nxt = tot_r + 24'd1;
      end else begin
        ob_nxt   = 8'h00;
        oisb_nxt = 1'b0;
        otot_nxt = sumtot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r  <= bytes_nxt;
    rem_r    <= rem_nxt;
    summ_r   <= summ_nxt;
    tot_r    <= tot_nxt;
    sumtot_r <= sumtot_nxt;
    ob_r     <= ob_nxt;
    oisb_r   <= oisb_nxt;
    olast_r  <= olast_nxt;
    otot_r   <= otot_nxt;
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_is_byte     = oisb_r;
  assign out_last_of_run = olast_r;
  assign out_byte_total  = otot_r;

endmodule

// ===== src/utf16_to_utf8_transcoder_unit.sv =====
// Top level of the UTF-16 to UTF-8 transcoder: input register, config registers, decode, output.
// An item passes the input register, the job register and the output register, in that order.
// One result leaves per cycle while out_stall is low; a new item loads as the last result leaves.
// Output delivers one result per cycle when not stalled; a 3-byte code point gives 3 byte results.
// Reset (rst_n low, synchronous) clears the pipeline, the held surrogate and the byte count,
// sets count_only to 0 and out_capacity to all ones.
module utf16_to_utf8_transcoder_unit import ut8_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_code_unit,
  input  logic              in_last_unit,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_is_byte,
  output logic              out_last_of_run,
  output logic [CountW-1:0] out_byte_total,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CountW-1:0] cfg_wdata
);

  logic              count_only_r;
  logic [CountW-1:0] out_capacity_r;
  logic              in_vld_r;
  unit_t             unit_r;
  logic              job_ready;
  job_t              job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_only_r   <= 1'b0;
      out_capacity_r <= COUNT_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT_ONLY:   count_only_r   <= cfg_wdata[0];
        CFG_OUT_CAPACITY: out_capacity_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = in_vld_r && !job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      unit_r.code_unit <= in_code_unit;
      unit_r.last_unit <= in_last_unit;
    end
  end

  ut8_dec u_dec (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (in_vld_r && job_ready),
    .unit         (unit_r),
    .count_only   (count_only_r),
    .out_capacity (out_capacity_r),
    .job          (job)
  );

  ut8_ser u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (in_vld_r),
    .job             (job),
    .job_ready       (job_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_byte     (out_is_byte),
    .out_last_of_run (out_last_of_run),
    .out_byte_total  (out_byte_total)
  );

endmodule

// ===== src/ut8_chk.sv =====
// Port-level checks for the transcoder and their binding to the top level.
module ut8_chk import ut8_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [15:0]       in_code_unit,
  input logic              in_last_unit,
  input logic              out_valid,
  input logic              out_stall,
  input logic [7:0]        out_byte,
  input logic              out_is_byte,
  input logic              out_last_of_run,
  input logic [CountW-1:0] out_byte_total
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_code_unit) && $stable(in_last_unit))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_is_byte)
      && $stable(out_last_of_run) && $stable(out_byte_total))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_byte |-> out_last_of_run && out_byte == 8'h00)
    else $error("summary not last or not zero");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_is_byte && !out_last_of_run ##1 out_valid && out_is_byte
      |-> out_byte_total == $past(out_byte_total) + 24'd1)
    else $error("byte total did not advance by one");

endmodule

bind utf16_to_utf8_transcoder_unit ut8_chk u_chk (.*);
